@@ design/mpm_pkg.sv @@
package mpm_pkg;

  localparam int MASK_W           = 4;
  localparam int NUM_PATTERN_REGS = 4;
  localparam int IGNORE_SLOTS     = 8;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_IDX_W        = 3;

  typedef logic [3:0]          pos_t;
  typedef logic [3:0]          len_t;
  typedef logic [MASK_W-1:0]   mask_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam pos_t POS_MAX = 4'd15;

  localparam cfg_idx_t CFG_PATTERN_0    = 3'd0;
  localparam cfg_idx_t CFG_PATTERN_1    = 3'd1;
  localparam cfg_idx_t CFG_PATTERN_2    = 3'd2;
  localparam cfg_idx_t CFG_PATTERN_3    = 3'd3;
  localparam cfg_idx_t CFG_LENGTHS      = 3'd4;
  localparam cfg_idx_t CFG_IGNORE_CHARS = 3'd5;
  localparam cfg_idx_t CFG_IGNORE_COUNT = 3'd6;

  typedef enum logic [1:0] {
    VERD_UNDECIDED = 2'd0,
    VERD_MATCHED   = 2'd1,
    VERD_FAILED    = 2'd2
  } verdict_t;

  // per-pattern compare outcome for one consumed byte
  typedef struct packed {
    logic keep;  // still matching, not complete
    logic hit;   // full length matched on this byte
  } lane_status_t;

endpackage

@@ design/multi_pattern_prefix_matcher.sv @@
// Byte-stream prefix matcher against up to four configured patterns.
// Input channel: in_char_in with in_restart, one byte per beat (valid/ready).
// Result channel: one beat per input beat carrying out_verdict (0 undecided,
// 1 matched, 2 failed), out_found_mask and out_open_mask.
// Ignored bytes leave the state untouched unless in_restart; others advance
// the position and are compared with every open pattern in the same cycle.
// Once no pattern is open the verdict sticks until a beat with in_restart.
// The result of a beat is registered and valid in the cycle after it is accepted.
// Throughput: one beat per cycle while out_ready is high; the byte compare,
// state update and result all sit between the state and output registers.
// in_ready is high when the output register is empty or is drained in the
// same cycle, so a stalled receiver holds the result and back-pressures the
// source after one beat.
// Reset clears all configuration registers, the position, the found set, the
// verdict and the output valid flag; beats are accepted right after reset.
// Configuration writes on cfg_we take effect at the next edge; write only
// while no beat is in flight.
module multi_pattern_prefix_matcher #(
  parameter int NUM_PATTERNS = 4,
  parameter int MAX_LEN      = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  mpm_pkg::cfg_idx_t           cfg_index,
  input  logic [mpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_char_in,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_verdict,
  output logic [3:0]                  out_found_mask,
  output logic [3:0]                  out_open_mask
);
  import mpm_pkg::*;

  localparam int NUM_LANES = (NUM_PATTERNS < NUM_PATTERN_REGS) ? NUM_PATTERNS
                                                               : NUM_PATTERN_REGS;
  localparam int PAT_W = 8 * MAX_LEN;

  logic [NUM_LANES-1:0][PAT_W-1:0] pattern_r;
  len_t [NUM_LANES-1:0]            len_r;
  logic [IGNORE_SLOTS*8-1:0]       ignore_chars_r;
  logic [3:0]                      ignore_count_r;

  pos_t     pos_r, pos_nxt;
  mask_t    open_r, open_nxt;
  mask_t    found_r, found_nxt;
  verdict_t verd_r, verd_nxt;

  logic     out_valid_r, out_valid_nxt;
  verdict_t out_verdict_r;
  mask_t    out_found_r;
  mask_t    out_open_r;
  mask_t    res_open;

  logic     in_fire;
  pos_t     pos_cur;
  mask_t    found_cur;
  verdict_t verd_cur;
  mask_t    open_cur;
  mask_t    nonempty;
  pos_t     step_pos;
  logic     ignored;
  logic     consume;
  mask_t    keep_mask;
  mask_t    hit_mask;

  lane_status_t [NUM_LANES-1:0] lane_status;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r      <= '0;
      len_r          <= '0;
      ignore_chars_r <= '0;
      ignore_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_0, CFG_PATTERN_1, CFG_PATTERN_2, CFG_PATTERN_3: begin
          for (int i = 0; i < NUM_LANES; i++) begin
            if (cfg_index == CFG_IDX_W'(i)) begin
              pattern_r[i] <= cfg_wdata[PAT_W-1:0];
            end
          end
        end
        CFG_LENGTHS: begin
          // clamp at write time; lengths are only read clamped
          for (int i = 0; i < NUM_LANES; i++) begin
            if (cfg_wdata[4*i +: 4] > 4'(MAX_LEN)) begin
              len_r[i] <= 4'(MAX_LEN);
            end else begin
              len_r[i] <= cfg_wdata[4*i +: 4];
            end
          end
        end
        CFG_IGNORE_CHARS: ignore_chars_r <= cfg_wdata[IGNORE_SLOTS*8-1:0];
        CFG_IGNORE_COUNT: ignore_count_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nonempty = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      nonempty[i] = (len_r[i] != 4'd0);
    end
  end

  always_comb begin
    pos_cur   = in_restart ? 4'd0 : pos_r;
    found_cur = in_restart ? '0 : found_r;
    verd_cur  = in_restart ? VERD_UNDECIDED : verd_r;
    open_cur  = (pos_cur == 4'd0) ? nonempty : open_r;
    step_pos  = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 4'd1;

    ignored = 1'b0;
    for (int j = 0; j < IGNORE_SLOTS; j++) begin
      if (4'(j) < ignore_count_r && ignore_chars_r[8*j +: 8] == in_char_in) begin
        ignored = 1'b1;
      end
    end
    consume = (verd_cur == VERD_UNDECIDED) && !ignored;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mpm_lane #(
      .MAX_LEN (MAX_LEN)
    ) u_lane (
      .pattern  (pattern_r[g]),
      .len      (len_r[g]),
      .step_pos (step_pos),
      .data     (in_char_in),
      .open     (open_cur[g]),
      .status   (lane_status[g])
    );
  end

  always_comb begin
    keep_mask = '0;
    hit_mask  = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      keep_mask[i] = lane_status[i].keep;
      hit_mask[i]  = lane_status[i].hit;
    end
  end

  // next state and result of the beat at the input
  always_comb begin
    pos_nxt   = pos_cur;
    found_nxt = found_cur;
    verd_nxt  = verd_cur;
    open_nxt  = in_restart ? nonempty : open_r;
    if (consume) begin
      pos_nxt   = step_pos;
      found_nxt = found_cur | hit_mask;
      open_nxt  = keep_mask;
      if (keep_mask == '0) begin
        verd_nxt = (found_nxt != '0) ? VERD_MATCHED : VERD_FAILED;
      end
    end
    if (verd_nxt != VERD_UNDECIDED) begin
      res_open = '0;
    end else if (pos_nxt == 4'd0) begin
      res_open = nonempty;
    end else begin
      res_open = open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      open_r  <= '0;
      found_r <= '0;
      verd_r  <= VERD_UNDECIDED;
    end else if (in_fire) begin
      pos_r   <= pos_nxt;
      open_r  <= open_nxt;
      found_r <= found_nxt;
      verd_r  <= verd_nxt;
    end
  end

  // output register: load on an input beat, drop when taken
  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_verdict_r <= verd_nxt;
      out_found_r   <= found_nxt;
      out_open_r    <= res_open;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_found_mask = out_found_r;
  assign out_open_mask  = out_open_r;

  a_decided_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_verdict_r != VERD_UNDECIDED |-> out_open_r == '0)
    else $error("open patterns reported with a decided verdict");

  a_matched_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_verdict_r == VERD_MATCHED |-> out_found_r != '0)
    else $error("matched verdict without a found pattern");

  a_found_not_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r & out_open_r) == '0)
    else $error("pattern both found and open");

  a_verdict_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_restart && verd_r != VERD_UNDECIDED |=> out_verdict_r == $past(verd_r))
    else $error("sticky verdict changed without restart");

endmodule

@@ design/mpm_lane.sv @@
module mpm_lane #(
  parameter int MAX_LEN = 8
) (
  input  logic [8*MAX_LEN-1:0] pattern,
  input  mpm_pkg::len_t        len,
  input  mpm_pkg::pos_t        step_pos,
  input  logic [7:0]           data,
  input  logic                 open,
  output mpm_pkg::lane_status_t status
);
  import mpm_pkg::*;

  pos_t idx;
  logic byte_eq;
  logic match;
  logic done;

  always_comb begin
    idx     = step_pos - 4'd1;
    byte_eq = 1'b0;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (idx == 4'(k) && pattern[8*k +: 8] == data) begin
        byte_eq = 1'b1;
      end
    end
    // a position at or past the pattern length drops the pattern
    match = open && byte_eq && (idx < len);
    done  = (len == step_pos);
    status.hit  = match && done;
    status.keep = match && !done;
  end

endmodule
